// ===== src/rrqs_pkg.sv =====
// Shared types and constants of the round-robin quantum scheduler.
package rrqs_pkg;

    localparam int SLICE_W = 8;
    localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd3;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_READY   = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_RUNNING = 2'd3
    } entry_state_t;

    typedef enum logic [2:0] {
        EV_IDLE      = 3'd0,
        EV_CONTINUED = 3'd1,
        EV_SWITCHED  = 3'd2,
        EV_STARTED   = 3'd3,
        EV_WRITTEN   = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_TICK,
        FSM_WRITE_RD,
        FSM_WRITE_WB,
        FSM_SCAN,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        entry_state_t       state;
        logic [SLICE_W-1:0] slice;
    } entry_t;

endpackage

// ===== src/round_robin_quantum_scheduler.sv =====
// Round-robin task scheduler with a time quantum over a table of task entries.
//
//  channel | direction | beat contents
//  s_*     | in        | tuser: operation; tdata: entry_index, entry_status
//  m_*     | out       | tuser: event_code; tdata: running_valid, running_index,
//          |           |        slice_left, tick_number
//  cfg_*   | in        | cfg_data: quantum
//
// A tick whose running task keeps going passes IDLE, TICK and DONE; a status write
// passes IDLE, WRITE_RD, WRITE_WB and DONE, or only IDLE and DONE when the write
// changes nothing (status code 3 or an index past the table). A tick that must pick
// a task scans the table through the single RAM read port, one entry a cycle.
// s_tready is high only while the sequencer is idle; a result held in the output
// register does not stop the next beat from being taken.
// Reset clears every entry to free at once through per-entry valid bits.
module round_robin_quantum_scheduler #(
    parameter int ENTRIES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] entry_index, [4:3] entry_status, [7:5] zero
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] running_valid, [3:1] running_index,
                                   // [11:4] slice_left, [43:12] tick_number, [47:44] zero
    output logic [2:0]  m_tuser,   // [2:0] event_code
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // quantum
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int XW    = (IDX_W > 3) ? IDX_W : 3;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int SW    = rrqs_pkg::SLICE_W;

    rrqs_pkg::fsm_t         fsm_reg, fsm_next;
    rrqs_pkg::event_t       event_reg, event_next;
    rrqs_pkg::entry_state_t status_reg, status_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [IDX_W-1:0]       chk_ptr_reg, chk_ptr_next;
    logic [CW-1:0]          issue_cnt_reg, issue_cnt_next;
    logic [CW-1:0]          chk_cnt_reg, chk_cnt_next;
    logic                   chk_pend_reg, chk_pend_next;
    logic                   fresh_reg, fresh_next;
    logic                   run_valid_reg, run_valid_next;
    logic [IDX_W-1:0]       run_index_reg, run_index_next;
    logic [SW-1:0]          run_slice_reg, run_slice_next;
    logic [31:0]            tick_reg, tick_next;
    logic [SW-1:0]          quantum_reg, quantum_next;
    logic [ENTRIES-1:0]     vld_reg, vld_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   out_valid_reg, out_valid_next;
    logic [47:0]            out_tdata_reg, out_tdata_next;
    logic [2:0]             out_tuser_reg, out_tuser_next;

    logic                   ram_wen;
    logic [IDX_W-1:0]       ram_waddr;
    rrqs_pkg::entry_t       ram_wdata;
    rrqs_pkg::entry_t       rd_entry;
    logic [$bits(rrqs_pkg::entry_t)-1:0] ram_rdata;

    logic                   in_accept;
    logic                   in_op;
    logic [XW-1:0]          in_idx_ext;
    logic [IDX_W-1:0]       in_idx;
    rrqs_pkg::entry_state_t in_status;
    logic                   wr_ok;
    rrqs_pkg::entry_state_t rd_state;
    logic                   issue_more;
    logic                   scan_hit;
    logic                   scan_end;
    logic                   out_load;
    logic [IDX_W-1:0]       ptr_wrap;
    logic [IDX_W-1:0]       run_wrap;
    logic [XW-1:0]          run_ext;

    rrqs_ram #(
        .WIDTH ($bits(rrqs_pkg::entry_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign s_tready  = (fsm_reg == rrqs_pkg::FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_tdata_reg;
    assign m_tuser   = out_tuser_reg;

    assign in_accept  = s_tvalid && s_tready;
    assign in_op      = s_tuser[0];
    assign in_idx_ext = XW'(s_tdata[2:0]);
    assign in_idx     = in_idx_ext[IDX_W-1:0];
    assign in_status  = rrqs_pkg::entry_state_t'(s_tdata[4:3]);
    assign wr_ok      = (32'(s_tdata[2:0]) < ENTRIES) && (in_status != rrqs_pkg::ST_RUNNING);

    assign rd_entry   = rrqs_pkg::entry_t'(ram_rdata);
    assign rd_state   = rd_vld_reg ? rd_entry.state : rrqs_pkg::ST_FREE;
    assign issue_more = (issue_cnt_reg < CW'(ENTRIES));
    assign scan_hit   = chk_pend_reg && (rd_state == rrqs_pkg::ST_READY);
    assign scan_end   = chk_pend_reg && (chk_cnt_reg == CW'(ENTRIES - 1));
    assign out_load   = !out_valid_reg || m_tready;

    assign ptr_wrap = (ptr_reg == IDX_W'(ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;
    assign run_wrap = (run_index_reg == IDX_W'(ENTRIES - 1)) ? '0 : run_index_reg + 1'b1;
    assign run_ext  = XW'(run_index_reg);

    // Next state
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            rrqs_pkg::FSM_IDLE:
            begin
                if (in_accept)
                begin
                    if (!in_op)
                    begin
                        fsm_next = run_valid_reg ? rrqs_pkg::FSM_TICK : rrqs_pkg::FSM_SCAN;
                    end
                    else
                    begin
                        fsm_next = wr_ok ? rrqs_pkg::FSM_WRITE_RD : rrqs_pkg::FSM_DONE;
                    end
                end
            end
            rrqs_pkg::FSM_TICK:
            begin
                fsm_next = (run_slice_reg <= SW'(1)) ? rrqs_pkg::FSM_SCAN : rrqs_pkg::FSM_DONE;
            end
            rrqs_pkg::FSM_WRITE_RD:
            begin
                fsm_next = rrqs_pkg::FSM_WRITE_WB;
            end
            rrqs_pkg::FSM_WRITE_WB:
            begin
                fsm_next = rrqs_pkg::FSM_DONE;
            end
            rrqs_pkg::FSM_SCAN:
            begin
                if (scan_hit || scan_end)
                begin
                    fsm_next = rrqs_pkg::FSM_DONE;
                end
            end
            rrqs_pkg::FSM_DONE:
            begin
                if (out_load)
                begin
                    fsm_next = rrqs_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                fsm_next = rrqs_pkg::FSM_IDLE;
            end
        endcase
    end

    // Datapath and table access
    always_comb
    begin
        event_next     = event_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        chk_ptr_next   = ptr_reg;
        issue_cnt_next = issue_cnt_reg;
        chk_cnt_next   = chk_cnt_reg;
        chk_pend_next  = (fsm_reg == rrqs_pkg::FSM_SCAN) && issue_more;
        fresh_next     = fresh_reg;
        run_valid_next = run_valid_reg;
        run_index_next = run_index_reg;
        run_slice_next = run_slice_reg;
        tick_next      = tick_reg;
        quantum_next   = cfg_valid ? cfg_data : quantum_reg;
        vld_next       = vld_reg;
        rd_vld_next    = vld_reg[ptr_reg];
        out_valid_next = out_valid_reg && !m_tready;
        out_tdata_next = out_tdata_reg;
        out_tuser_next = out_tuser_reg;
        ram_wen        = 1'b0;
        ram_waddr      = run_index_reg;
        ram_wdata      = '0;

        unique case (fsm_reg)
            rrqs_pkg::FSM_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next       = in_idx;
                    status_next    = in_status;
                    issue_cnt_next = '0;
                    chk_cnt_next   = '0;
                    if (!in_op)
                    begin
                        tick_next  = tick_reg + 32'd1;
                        ptr_next   = '0;
                        fresh_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next   = in_idx;
                        event_next = rrqs_pkg::EV_WRITTEN;
                    end
                end
            end
            rrqs_pkg::FSM_TICK:
            begin
                ram_wen = 1'b1;
                if (run_slice_reg <= SW'(1))
                begin
                    // expire: back to ready with a full slice, then look past it
                    ram_wdata.state = rrqs_pkg::ST_READY;
                    ram_wdata.slice = quantum_reg;
                    ptr_next        = run_wrap;
                    fresh_next      = 1'b0;
                end
                else
                begin
                    ram_wdata.state = rrqs_pkg::ST_RUNNING;
                    ram_wdata.slice = run_slice_reg - 1'b1;
                    run_slice_next  = run_slice_reg - 1'b1;
                    event_next      = rrqs_pkg::EV_CONTINUED;
                end
            end
            rrqs_pkg::FSM_WRITE_RD:
            begin
                // hold the read address on the written entry
            end
            rrqs_pkg::FSM_WRITE_WB:
            begin
                ram_wen         = 1'b1;
                ram_waddr       = idx_reg;
                ram_wdata.state = status_reg;
                ram_wdata.slice = ((rd_state == rrqs_pkg::ST_FREE)
                                   && (status_reg != rrqs_pkg::ST_FREE))
                                  ? quantum_reg : rd_entry.slice;
                vld_next[idx_reg] = 1'b1;
                if (run_valid_reg && (run_index_reg == idx_reg))
                begin
                    run_valid_next = 1'b0;
                    run_index_next = '0;
                end
            end
            rrqs_pkg::FSM_SCAN:
            begin
                if (issue_more)
                begin
                    ptr_next       = ptr_wrap;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (chk_pend_reg)
                begin
                    chk_cnt_next = chk_cnt_reg + 1'b1;
                end
                if (scan_hit)
                begin
                    ram_wen         = 1'b1;
                    ram_waddr       = chk_ptr_reg;
                    ram_wdata.state = rrqs_pkg::ST_RUNNING;
                    ram_wdata.slice = fresh_reg ? quantum_reg : rd_entry.slice;
                    run_valid_next  = 1'b1;
                    run_index_next  = chk_ptr_reg;
                    run_slice_next  = fresh_reg ? quantum_reg : rd_entry.slice;
                    event_next      = fresh_reg ? rrqs_pkg::EV_STARTED : rrqs_pkg::EV_SWITCHED;
                end
                else if (scan_end)
                begin
                    run_valid_next = 1'b0;
                    run_index_next = '0;
                    event_next     = fresh_reg ? rrqs_pkg::EV_IDLE : rrqs_pkg::EV_SWITCHED;
                end
            end
            rrqs_pkg::FSM_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next        = 1'b1;
                    out_tdata_next        = '0;
                    out_tdata_next[0]     = run_valid_reg;
                    out_tdata_next[3:1]   = run_valid_reg ? run_ext[2:0] : 3'd0;
                    out_tdata_next[11:4]  = run_valid_reg ? run_slice_reg : '0;
                    out_tdata_next[43:12] = tick_reg;
                    out_tuser_next        = event_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= rrqs_pkg::FSM_IDLE;
            chk_pend_reg  <= 1'b0;
            run_valid_reg <= 1'b0;
            run_index_reg <= '0;
            tick_reg      <= '0;
            quantum_reg   <= rrqs_pkg::QUANTUM_RESET;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            issue_cnt_reg <= '0;
            chk_cnt_reg   <= '0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            chk_pend_reg  <= chk_pend_next;
            run_valid_reg <= run_valid_next;
            run_index_reg <= run_index_next;
            tick_reg      <= tick_next;
            quantum_reg   <= quantum_next;
            vld_reg       <= vld_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            issue_cnt_reg <= issue_cnt_next;
            chk_cnt_reg   <= chk_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_reg     <= event_next;
        status_reg    <= status_next;
        idx_reg       <= idx_next;
        ptr_reg       <= ptr_next;
        chk_ptr_reg   <= chk_ptr_next;
        fresh_reg     <= fresh_next;
        run_slice_reg <= run_slice_next;
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while the sequencer was busy");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(fsm_reg == rrqs_pkg::FSM_DONE))
        else $error("result raised outside the completion step");

    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready && !s_tuser[0]) |=> $stable(tick_reg))
        else $error("tick count moved without a tick beat");
`endif

endmodule

// ===== src/rrqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrqs_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
